>>> src/txtea_pkg.sv
// ----------------------------------------------------------------------------
// txtea_pkg: shared types and constants of the triple XTEA cipher
// Holds the block and key types, the register indexes of the CSR port
// and the round-sum helper used to build per-stage constants.
// ----------------------------------------------------------------------------
package txtea_pkg;

   // Key schedule constant
   localparam logic [31:0] DELTA = 32'h9E37_79B9;

   localparam int NUM_KEYS   = 3;
   localparam int KEY_WORDS  = 4;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;

   // CSR register indexes
   localparam logic [CSR_IDX_W-1:0] REG_DECRYPT_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_ONE_01     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_ONE_23     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TWO_01     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_TWO_23     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_THREE_01   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_KEY_THREE_23   = 3'd6;

   // Four 32-bit key words, word 0 at index 0
   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   // Request and response payloads
   typedef struct packed {
      logic [31:0] block_first_half;
      logic [31:0] block_second_half;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_first_half;
      logic [31:0] out_second_half;
   } rsp_payload_type;

   // Block as it moves down the pipeline
   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
   } block_type;

   // Per-stage control
   typedef struct packed {
      logic advance;
      logic decrypt;
   } stage_ctrl_type;

   // Round sum after n additions of DELTA, modulo 2^32 (elaboration only)
   function automatic logic [31:0] round_sum(int unsigned n);
      logic [63:0] prod;
      prod = 64'(DELTA) * 64'(n);
      return prod[31:0];
   endfunction

endpackage

>>> src/txtea_chan_if.sv
// ----------------------------------------------------------------------------
// txtea_chan_if: valid/ready channel
// Carries valid, ready and a payload whose type the instance selects.
// ----------------------------------------------------------------------------
interface txtea_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> src/txtea_stage.sv
// ----------------------------------------------------------------------------
// txtea_stage: one registered half-round
// Updates one half of the block with the Feistel term of the other half.
// Encrypt adds the term, decrypt subtracts it; round sum is fixed per stage.
// ----------------------------------------------------------------------------
module txtea_stage #(
   parameter logic [31:0] SUM_ENC  = 32'h0,
   parameter logic [31:0] SUM_DEC  = 32'h0,
   parameter bit          ENC_OP_B = 1'b0
) (
   input  logic                       clock,
   input  logic                       reset,
   input  txtea_pkg::stage_ctrl_type  ctrl,
   input  txtea_pkg::key_type         key_enc,
   input  txtea_pkg::key_type         key_dec,
   input  logic                       in_valid,
   input  txtea_pkg::block_type       in_data,
   output logic                       out_valid,
   output txtea_pkg::block_type       out_data
);

   logic                  valid_ff, valid_in;
   txtea_pkg::block_type  data_ff, data_in;

   logic                  op_b;
   logic [31:0]           sum;
   txtea_pkg::key_type    key;
   logic [1:0]            key_idx;
   logic [31:0]           src;
   logic [31:0]           dst;
   logic [31:0]           term;
   logic [31:0]           dst_new;

   // Decrypt runs the halves in the opposite order
   assign op_b    = ENC_OP_B ^ ctrl.decrypt;
   assign sum     = ctrl.decrypt ? SUM_DEC : SUM_ENC;
   assign key     = ctrl.decrypt ? key_dec : key_enc;
   assign key_idx = op_b ? sum[12:11] : sum[1:0];
   assign src     = op_b ? in_data.x : in_data.y;
   assign dst     = op_b ? in_data.y : in_data.x;

   // Feistel term: (src ^ sum) + key word + ((src << 4) ^ (src >> 5))
   assign term    = (src ^ sum) + key[key_idx] + ((src << 4) ^ (src >> 5));
   assign dst_new = ctrl.decrypt ? (dst - term) : (dst + term);

   always_comb begin
      data_in = in_data;
      if (op_b) begin
         data_in.y = dst_new;
      end else begin
         data_in.x = dst_new;
      end
      valid_in = in_valid;
   end

   // Stage register, shifts when the pipeline advances
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> src/txtea_out_buf.sv
// ----------------------------------------------------------------------------
// txtea_out_buf: output register with skid stage
// Decouples the response handshake from the pipeline; the pipeline
// stalls only when both the output and the skid register hold a block.
// ----------------------------------------------------------------------------
module txtea_out_buf (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  txtea_pkg::block_type  in_data,
   output logic                  in_ready,
   txtea_chan_if.source          rsp_chan
);

   logic                  out_valid_ff, out_valid_in;
   txtea_pkg::block_type  out_data_ff, out_data_in;
   logic                  skid_valid_ff, skid_valid_in;
   txtea_pkg::block_type  skid_data_ff, skid_data_in;
   logic                  push;
   logic                  out_free;

   assign in_ready = !skid_valid_ff;
   assign push     = in_valid && !skid_valid_ff;
   assign out_free = !out_valid_ff || rsp_chan.ready;

   // Next-state for output and skid registers
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in  = push;
            out_data_in   = in_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid                  = out_valid_ff;
   assign rsp_chan.payload.out_first_half  = out_data_ff.x;
   assign rsp_chan.payload.out_second_half = out_data_ff.y;

   // Skid holds a block only behind a held output
   a_skid_behind_out: assert property (
      @(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff
   ) else $error("skid register valid while output register empty");

   // A block arriving at a stalled output lands in the skid register
   a_stall_to_skid: assert property (
      @(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_chan.ready && push) |=>
         (skid_valid_ff && skid_data_ff == $past(in_data))
   ) else $error("block lost at stalled output");

   // Skid drains into the output once the output transfer completes
   a_skid_drain: assert property (
      @(posedge clock) disable iff (reset)
      (skid_valid_ff && rsp_chan.ready) |=>
         (out_valid_ff && !skid_valid_ff && out_data_ff == $past(skid_data_ff))
   ) else $error("skid register did not drain in order");

   // A block arriving at a free output goes straight through
   a_direct_load: assert property (
      @(posedge clock) disable iff (reset)
      (push && out_free && !skid_valid_ff) |=>
         (out_valid_ff && out_data_ff == $past(in_data))
   ) else $error("block not loaded into output register");

endmodule

>>> src/triple_xtea_block_cipher.sv
// ----------------------------------------------------------------------------
// triple_xtea_block_cipher: triple XTEA ECB cipher, fully unrolled
// Encrypts with keys one, two, three or decrypts with keys three, two, one,
// one registered half-round per stage, followed by an output skid buffer.
// ----------------------------------------------------------------------------
// Pipeline: one register per half-round between request and response transfer,
//          plus the output register.
// Throughput: one block per cycle; the pipeline stalls only when the output
//          and skid registers are both full.
// Reset: synchronous, clears all valid bits, the mode and the three keys.
module triple_xtea_block_cipher #(
   parameter int ROUND_CYCLES = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_write_enable,
   input  logic [txtea_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [txtea_pkg::CSR_DATA_W-1:0]      csr_write_data,
   txtea_chan_if.sink                            req_chan,
   txtea_chan_if.source                          rsp_chan
);

   localparam int NUM_STAGES = 2 * txtea_pkg::NUM_KEYS * ROUND_CYCLES;
   localparam int PASS_STAGES = 2 * ROUND_CYCLES;

   logic                                       mode_ff, mode_in;
   txtea_pkg::key_type [txtea_pkg::NUM_KEYS-1:0] keys_ff, keys_in;

   logic                       advance;
   txtea_pkg::stage_ctrl_type  ctrl;
   logic                       stage_valid [NUM_STAGES+1];
   txtea_pkg::block_type       stage_data  [NUM_STAGES+1];

   // CSR writes
   always_comb begin
      mode_in = mode_ff;
      keys_in = keys_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            txtea_pkg::REG_DECRYPT_MODE: mode_in = csr_write_data[0];
            txtea_pkg::REG_KEY_ONE_01: begin
               keys_in[0][0] = csr_write_data[63:32];
               keys_in[0][1] = csr_write_data[31:0];
            end
            txtea_pkg::REG_KEY_ONE_23: begin
               keys_in[0][2] = csr_write_data[63:32];
               keys_in[0][3] = csr_write_data[31:0];
            end
            txtea_pkg::REG_KEY_TWO_01: begin
               keys_in[1][0] = csr_write_data[63:32];
               keys_in[1][1] = csr_write_data[31:0];
            end
            txtea_pkg::REG_KEY_TWO_23: begin
               keys_in[1][2] = csr_write_data[63:32];
               keys_in[1][3] = csr_write_data[31:0];
            end
            txtea_pkg::REG_KEY_THREE_01: begin
               keys_in[2][0] = csr_write_data[63:32];
               keys_in[2][1] = csr_write_data[31:0];
            end
            txtea_pkg::REG_KEY_THREE_23: begin
               keys_in[2][2] = csr_write_data[63:32];
               keys_in[2][3] = csr_write_data[31:0];
            end
            default: ;  // unmapped index, write dropped
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         keys_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         keys_ff <= keys_in;
      end
   end

   // Whole pipeline shifts together while the skid register is free
   assign ctrl.advance   = advance;
   assign ctrl.decrypt   = mode_ff;
   assign req_chan.ready = advance;

   assign stage_valid[0]  = req_chan.valid;
   assign stage_data[0].x = req_chan.payload.block_first_half;
   assign stage_data[0].y = req_chan.payload.block_second_half;

   // Half-round stages; encrypt does x then y per round, decrypt y then x
   for (genvar g = 0; g < NUM_STAGES; g++) begin : g_stage
      localparam int PASS = g / PASS_STAGES;
      localparam int RND  = (g % PASS_STAGES) / 2;
      localparam bit ODD  = (g % 2) == 1;
      localparam logic [31:0] SUM_ENC = ODD ?
         txtea_pkg::round_sum(RND + 1) : txtea_pkg::round_sum(RND);
      localparam logic [31:0] SUM_DEC = ODD ?
         txtea_pkg::round_sum(ROUND_CYCLES - RND - 1) :
         txtea_pkg::round_sum(ROUND_CYCLES - RND);

      txtea_stage #(
         .SUM_ENC  (SUM_ENC),
         .SUM_DEC  (SUM_DEC),
         .ENC_OP_B (ODD)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .key_enc   (keys_ff[2'(PASS)]),
         .key_dec   (keys_ff[2'(txtea_pkg::NUM_KEYS - 1 - PASS)]),
         .in_valid  (stage_valid[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   // Output register and skid stage
   txtea_out_buf u_out_buf (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid[NUM_STAGES]),
      .in_data  (stage_data[NUM_STAGES]),
      .in_ready (advance),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> bench/triple_xtea_block_cipher_tb.sv
// ----------------------------------------------------------------------------
// triple_xtea_block_cipher_tb: self-checking bench for the triple XTEA cipher
// Drives 64-bit blocks into the request channel and checks every response
// against a behavioral model of the cipher in both directions. Keys and mode
// change between phases once the pipeline has drained. Directed phases cover
// zero keys, all-ones keys, ignored mode bits and writes to the unused index.
// Random phases follow. Both channels idle at random, except during one
// stretch where they run at full rate.
// ----------------------------------------------------------------------------
module triple_xtea_block_cipher_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ROUNDS        = 32;
   localparam int STALL_PERCENT = 14;
   localparam int WATCHDOG_MAX  = 4000;
   localparam int SETTLE_CYCLES = 6 * ROUNDS + 20;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_BLOCKS  = 250;
   // full-rate window, counted in transfers on each side
   localparam int STEADY_FIRST  = 800;
   localparam int STEADY_LAST   = 1100;
   // index 7 maps to no register; writes to it must be dropped
   localparam logic [txtea_pkg::CSR_IDX_W-1:0] UNUSED_REG_INDEX = 3'd7;
   localparam logic [31:0] DECIPHER_START = 32'(txtea_pkg::DELTA * ROUNDS);

   logic                             clock;
   logic                             reset;
   logic                             csr_write_enable;
   logic [txtea_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [txtea_pkg::CSR_DATA_W-1:0] csr_write_data;

   txtea_chan_if #(.payload_type(txtea_pkg::req_payload_type)) req_chan ();
   txtea_chan_if #(.payload_type(txtea_pkg::rsp_payload_type)) rsp_chan ();

   triple_xtea_block_cipher #(
      .ROUND_CYCLES(ROUNDS)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan)
   );

   // Shadow copy of the cipher configuration
   logic        decrypt_active;
   logic [31:0] key_words [3][4];

   txtea_pkg::req_payload_type pending_blocks[$];
   txtea_pkg::rsp_payload_type cipher_outputs[$];
   txtea_pkg::rsp_payload_type want;

   int errors;
   int blocks_driven;
   int blocks_accepted;
   int blocks_checked;
   int decrypt_blocks;
   int settings_used;
   int idle_cycles;

   // Three XTEA passes: keys 0,1,2 forward, or keys 2,1,0 backward
   function automatic txtea_pkg::rsp_payload_type cipher_block(
      txtea_pkg::req_payload_type blk);
      txtea_pkg::rsp_payload_type res;
      logic [31:0]     x;
      logic [31:0]     y;
      logic [31:0]     s;
      int              k;
      int              r;
      x = blk.block_first_half;
      y = blk.block_second_half;
      for (int n = 0; n < 3; n++) begin
         k = decrypt_active ? 2 - n : n;
         if (decrypt_active) begin
            s = DECIPHER_START;
            for (r = 0; r < ROUNDS; r++) begin
               y -= key_words[k][s[12:11]] + (x ^ s) + ((x << 4) ^ (x >> 5));
               s -= txtea_pkg::DELTA;
               x -= ((y ^ s) + key_words[k][s[1:0]]) + ((y << 4) ^ (y >> 5));
            end
         end else begin
            s = '0;
            for (r = 0; r < ROUNDS; r++) begin
               x += ((y ^ s) + key_words[k][s[1:0]]) + ((y << 4) ^ (y >> 5));
               s += txtea_pkg::DELTA;
               y += key_words[k][s[12:11]] + (x ^ s) + ((x << 4) ^ (x >> 5));
            end
         end
      end
      res.out_first_half  = x;
      res.out_second_half = y;
      return res;
   endfunction

   // One register write per rising edge; the shadow copy follows along
   task automatic write_reg(logic [txtea_pkg::CSR_IDX_W-1:0] idx,
                            logic [txtea_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      case (idx)
         txtea_pkg::REG_DECRYPT_MODE: decrypt_active = data[0];
         txtea_pkg::REG_KEY_ONE_01: begin
            key_words[0][0] = data[63:32];
            key_words[0][1] = data[31:0];
         end
         txtea_pkg::REG_KEY_ONE_23: begin
            key_words[0][2] = data[63:32];
            key_words[0][3] = data[31:0];
         end
         txtea_pkg::REG_KEY_TWO_01: begin
            key_words[1][0] = data[63:32];
            key_words[1][1] = data[31:0];
         end
         txtea_pkg::REG_KEY_TWO_23: begin
            key_words[1][2] = data[63:32];
            key_words[1][3] = data[31:0];
         end
         txtea_pkg::REG_KEY_THREE_01: begin
            key_words[2][0] = data[63:32];
            key_words[2][1] = data[31:0];
         end
         txtea_pkg::REG_KEY_THREE_23: begin
            key_words[2][2] = data[63:32];
            key_words[2][3] = data[31:0];
         end
         default: ;
      endcase
   endtask

   task automatic close_writes();
      @(posedge clock);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic queue_block(logic [31:0] first, logic [31:0] second);
      txtea_pkg::req_payload_type blk;
      blk.block_first_half  = first;
      blk.block_second_half = second;
      pending_blocks.push_back(blk);
   endtask

   // Pipeline empty: nothing queued, nothing offered, nothing outstanding
   task automatic wait_drained();
      @(negedge clock);
      while (pending_blocks.size() != 0 || req_chan.valid || cipher_outputs.size() != 0)
         @(negedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Request driver: a new block is offered once the previous one transferred
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_chan.ready) begin
         if (pending_blocks.size() != 0 &&
             ((blocks_driven >= STEADY_FIRST && blocks_driven < STEADY_LAST) ||
              $urandom_range(0, 99) >= STALL_PERCENT)) begin
            req_chan.payload <= pending_blocks.pop_front();
            req_chan.valid   <= 1'b1;
            blocks_driven++;
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Response monitor: predict on request transfer, check on response transfer
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            cipher_outputs.push_back(cipher_block(req_chan.payload));
            blocks_accepted++;
            if (decrypt_active)
               decrypt_blocks++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (cipher_outputs.size() == 0) begin
               $error("response transfer with no block outstanding");
               errors++;
            end else begin
               want = cipher_outputs.pop_front();
               if (rsp_chan.payload.out_first_half !== want.out_first_half) begin
                  $error("out_first_half: expected %h, got %h",
                         want.out_first_half, rsp_chan.payload.out_first_half);
                  errors++;
               end
               if (rsp_chan.payload.out_second_half !== want.out_second_half) begin
                  $error("out_second_half: expected %h, got %h",
                         want.out_second_half, rsp_chan.payload.out_second_half);
                  errors++;
               end
               blocks_checked++;
            end
         end
         rsp_chan.ready <= (blocks_checked >= STEADY_FIRST && blocks_checked < STEADY_LAST) ||
                           $urandom_range(0, 99) >= STALL_PERCENT;
      end
   end

   // Watchdog: too long without any transfer on either channel
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_MAX) begin
         $display("Timeout: no transfer for %0d cycles", idle_cycles);
         $display("TB_ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus
   initial begin
      logic [63:0] corner_blocks [6];
      logic [txtea_pkg::CSR_IDX_W-1:0] reg_order [8];
      logic [txtea_pkg::CSR_DATA_W-1:0] data;

      corner_blocks = '{64'h00000000_00000000, 64'hFFFFFFFF_FFFFFFFF,
                        64'h80000000_00000001, 64'h00000001_80000000,
                        64'hAAAAAAAA_55555555, 64'h12345678_9ABCDEF0};
      reg_order = '{txtea_pkg::REG_DECRYPT_MODE, txtea_pkg::REG_KEY_ONE_01,
                    txtea_pkg::REG_KEY_ONE_23, txtea_pkg::REG_KEY_TWO_01,
                    txtea_pkg::REG_KEY_TWO_23, txtea_pkg::REG_KEY_THREE_01,
                    txtea_pkg::REG_KEY_THREE_23, UNUSED_REG_INDEX};

      errors = 0;
      blocks_driven = 0;
      blocks_accepted = 0;
      blocks_checked = 0;
      decrypt_blocks = 0;
      settings_used = 1;
      idle_cycles = 0;
      decrypt_active = 1'b0;
      for (int k = 0; k < 3; k++)
         for (int w = 0; w < 4; w++)
            key_words[k][w] = '0;

      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = '0;
      csr_write_data = '0;
      req_chan.valid = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Reset values: zero keys, encrypt
      @(negedge clock);
      foreach (corner_blocks[i])
         queue_block(corner_blocks[i][63:32], corner_blocks[i][31:0]);
      wait_drained();

      // All-ones keys, mode with every upper bit set but bit 0 clear
      write_reg(txtea_pkg::REG_DECRYPT_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
      for (int i = 1; i < 7; i++)
         write_reg(reg_order[i], '1);
      write_reg(UNUSED_REG_INDEX, 64'h0123_4567_89AB_CDEF);
      close_writes();
      @(negedge clock);
      foreach (corner_blocks[i])
         queue_block(corner_blocks[i][63:32], corner_blocks[i][31:0]);
      wait_drained();

      // Decrypt with all-ones keys
      write_reg(txtea_pkg::REG_DECRYPT_MODE, 64'h0000_0000_0000_0001);
      close_writes();
      @(negedge clock);
      foreach (corner_blocks[i])
         queue_block(corner_blocks[i][63:32], corner_blocks[i][31:0]);
      wait_drained();

      // Random keys, decrypt selected with noise in the upper bits
      write_reg(txtea_pkg::REG_DECRYPT_MODE, {$urandom, $urandom} | 64'd1);
      for (int i = 1; i < 7; i++)
         write_reg(reg_order[i], {$urandom, $urandom});
      close_writes();
      @(negedge clock);
      foreach (corner_blocks[i])
         queue_block(corner_blocks[i][63:32], corner_blocks[i][31:0]);
      wait_drained();

      // Random phases: a random subset of registers rewritten each time
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         foreach (reg_order[i]) begin
            if ($urandom_range(0, 1) == 1) begin
               case ($urandom_range(0, 9))
                  0:       data = '0;
                  1:       data = '1;
                  default: data = {$urandom, $urandom};
               endcase
               write_reg(reg_order[i], data);
            end
         end
         close_writes();
         @(negedge clock);
         for (int n = 0; n < PHASE_BLOCKS; n++)
            queue_block(pick_word(), pick_word());
         wait_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Checked %0d of %0d blocks under %0d key/mode settings.",
               blocks_checked, blocks_accepted, settings_used);
      $display("%0d blocks went through the decrypt direction.", decrypt_blocks);
      if (errors == 0 && cipher_outputs.size() == 0 && blocks_checked == blocks_accepted)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
